>>> sv/dnsp_pkg.sv
// ----------------------------------------------------------------------------
// dnsp_pkg
// Types and constants shared by the DNS response address parser modules.
// ----------------------------------------------------------------------------
package dnsp_pkg;

  // register indexes (word address paddr[2])
  localparam logic REG_TXID = 1'b0;

  localparam logic [3:0]  HDR_LEN    = 4'd12;
  localparam logic [3:0]  QFIXED_LEN = 4'd4;
  localparam logic [3:0]  AFIXED_LEN = 4'd10;
  localparam logic [3:0]  TYPE_END   = 4'd2;
  localparam logic [3:0]  RDLEN_POS  = 4'd8;
  localparam logic [3:0]  ADDR_LEN   = 4'd4;
  localparam logic [7:0]  RCODE_MASK = 8'h0F;
  localparam logic [7:0]  PTR_MASK   = 8'hC0;
  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] RDLEN_A    = 16'd4;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QFIXED = 3'd2,
    PH_ANAME  = 3'd3,
    PH_AFIXED = 3'd4,
    PH_RDATA  = 3'd5,
    PH_ADDR   = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
  } dnsp_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] ipv4_address;
  } dnsp_out_t;

  // one result from the parser toward the output register
  typedef struct packed {
    logic      valid;
    dnsp_out_t data;
  } dnsp_res_t;

  typedef struct packed {
    logic [3:0]  header_index;
    phase_t      section_phase;
    logic [15:0] questions_left;
    logic [15:0] answers_left;
    logic [7:0]  label_bytes_left;
    logic [3:0]  field_index;
    logic [15:0] record_type;
    logic [15:0] rdata_left;
    logic [31:0] address_shift;
    logic        found_flag;
  } dnsp_state_t;

  localparam dnsp_state_t STATE_CLEAR = '{
    header_index:     4'd0,
    section_phase:    PH_HEADER,
    questions_left:   16'd0,
    answers_left:     16'd0,
    label_bytes_left: 8'd0,
    field_index:      4'd0,
    record_type:      16'd0,
    rdata_left:       16'd0,
    address_shift:    32'd0,
    found_flag:       1'b0
  };

endpackage

>>> sv/dnsp_cfg.sv
// ----------------------------------------------------------------------------
// dnsp_cfg
// APB register bank holding the expected transaction id.
// ----------------------------------------------------------------------------
module dnsp_cfg import dnsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] cfg_txid
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_txid <= 16'd0;
    end else if (wr_en && paddr[2] == REG_TXID) begin
      cfg_txid <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_TXID) ? {16'd0, cfg_txid} : 32'd0;

endmodule

>>> sv/dnsp_parser.sv
// ----------------------------------------------------------------------------
// dnsp_parser
// Per-byte parse state and its update; flags the result on the final byte.
// ----------------------------------------------------------------------------
module dnsp_parser import dnsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  dnsp_in_t    in_item,
  input  logic [15:0] cfg_txid,
  output dnsp_res_t   res
);

  dnsp_state_t st;
  dnsp_state_t st_next;
  dnsp_state_t upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [15:0] rt_shift;
    logic [15:0] ans_dec;
    logic [15:0] q_dec;
    logic [15:0] rd_dec;
    logic [15:0] rd_shift;
    logic [15:0] rt_new;
    logic [15:0] rd_new;
    logic [7:0]  lbl_dec;
    logic [3:0]  fi_inc;
    logic [3:0]  hi_inc;
    logic        name_end;

    b        = in_item.packet_byte;
    upd      = st;
    rt_shift = {st.record_type[7:0], b};
    rd_shift = {st.rdata_left[7:0], b};
    ans_dec  = st.answers_left - 16'd1;
    q_dec    = st.questions_left - 16'd1;
    rd_dec   = st.rdata_left - 16'd1;
    lbl_dec  = st.label_bytes_left - 8'd1;
    fi_inc   = st.field_index + 4'd1;
    hi_inc   = st.header_index + 4'd1;
    name_end = 1'b0;
    rt_new   = st.record_type;
    rd_new   = st.rdata_left;

    unique case (st.section_phase)
      PH_HEADER: begin
        if (st.header_index < 4'd2) begin
          upd.record_type = rt_shift;
        end else if (st.header_index >= 4'd4 && st.header_index < 4'd6) begin
          upd.questions_left = {st.questions_left[7:0], b};
        end else if (st.header_index >= 4'd6 && st.header_index < 4'd8) begin
          upd.answers_left = {st.answers_left[7:0], b};
        end
        if (st.header_index == 4'd1 && rt_shift != cfg_txid) begin
          upd.section_phase = PH_DONE;
        end else if (st.header_index == 4'd3 && (b & RCODE_MASK) != 8'd0) begin
          upd.section_phase = PH_DONE;
        end else begin
          upd.header_index = hi_inc;
          if (hi_inc == HDR_LEN) begin
            upd.record_type = 16'd0;
            if (st.answers_left == 16'd0) begin
              upd.section_phase = PH_DONE;
            end else begin
              upd.label_bytes_left = 8'd0;
              upd.field_index      = 4'd0;
              upd.section_phase    = (st.questions_left == 16'd0) ? PH_ANAME : PH_QNAME;
            end
          end
        end
      end
      PH_QNAME, PH_ANAME: begin
        // label body, compression pointer, root or label length
        if (st.label_bytes_left != 8'd0) begin
          upd.label_bytes_left = lbl_dec;
          name_end = (lbl_dec == 8'd0) && (st.field_index == 4'd1);
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          upd.label_bytes_left = 8'd1;
          upd.field_index      = 4'd1;
        end else if (b == 8'd0) begin
          name_end = 1'b1;
        end else begin
          upd.label_bytes_left = b;
          upd.field_index      = 4'd0;
        end
        if (name_end) begin
          upd.field_index   = 4'd0;
          upd.section_phase = (st.section_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
        end
      end
      PH_QFIXED: begin
        upd.field_index = fi_inc;
        if (fi_inc == QFIXED_LEN) begin
          upd.questions_left   = q_dec;
          upd.label_bytes_left = 8'd0;
          upd.field_index      = 4'd0;
          upd.section_phase    = (q_dec == 16'd0) ? PH_ANAME : PH_QNAME;
        end
      end
      PH_AFIXED: begin
        if (st.field_index < TYPE_END) begin
          rt_new = rt_shift;
        end else if (st.field_index >= RDLEN_POS) begin
          rd_new = rd_shift;
        end
        upd.record_type = rt_new;
        upd.rdata_left  = rd_new;
        upd.field_index = fi_inc;
        if (fi_inc == AFIXED_LEN) begin
          upd.field_index = 4'd0;
          upd.record_type = 16'd0;
          if (rt_new == TYPE_A && rd_new == RDLEN_A) begin
            upd.section_phase = PH_ADDR;
            upd.address_shift = 32'd0;
          end else if (rd_new != 16'd0) begin
            upd.section_phase = PH_RDATA;
          end else begin
            upd.answers_left = ans_dec;
            if (ans_dec == 16'd0) begin
              upd.section_phase = PH_DONE;
            end else begin
              upd.section_phase    = PH_ANAME;
              upd.label_bytes_left = 8'd0;
            end
          end
        end
      end
      PH_RDATA: begin
        upd.rdata_left = rd_dec;
        if (rd_dec == 16'd0) begin
          upd.answers_left = ans_dec;
          if (ans_dec == 16'd0) begin
            upd.section_phase = PH_DONE;
          end else begin
            upd.section_phase    = PH_ANAME;
            upd.label_bytes_left = 8'd0;
            upd.field_index      = 4'd0;
          end
        end
      end
      PH_ADDR: begin
        upd.address_shift = {st.address_shift[23:0], b};
        upd.field_index   = fi_inc;
        if (fi_inc == ADDR_LEN) begin
          upd.found_flag    = 1'b1;
          upd.section_phase = PH_DONE;
        end
      end
      PH_DONE: begin
        // rest of the packet is ignored
      end
      default: begin
      end
    endcase

    // final byte: report and start over for the next packet
    st_next = in_item.end_of_packet ? STATE_CLEAR : upd;
  end

  assign res.valid             = accept && in_item.end_of_packet;
  assign res.data.status       = !upd.found_flag;
  assign res.data.ipv4_address = upd.found_flag ? upd.address_shift : 32'd0;

endmodule

>>> sv/dnsp_result.sv
// ----------------------------------------------------------------------------
// dnsp_result
// Output register for the result channel.
// ----------------------------------------------------------------------------
module dnsp_result import dnsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dnsp_res_t res,
  output logic      result_valid,
  input  logic      result_stall,
  output dnsp_out_t result_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result_data <= res.data;
    end
  end

endmodule

>>> sv/dns_response_address_parser.sv
// ----------------------------------------------------------------------------
// dns_response_address_parser
// Byte-serial DNS response parser giving the first A record address.
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle and updates a small parse state in that
// same cycle; the final byte (end_of_packet set) produces one result, status
// plus IPv4 address, in the output register on the next cycle. Throughput is
// one byte per clock. Only a final byte is held off, and only while the
// previous result is still waiting and stalled in the output register. The
// expected transaction id is written over APB at byte address 0 and should be
// changed only between packets.
// ----------------------------------------------------------------------------
module dns_response_address_parser import dnsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  dnsp_in_t    byte_data,
  output logic        result_valid,
  input  logic        result_stall,
  output dnsp_out_t   result_data
);

  logic [15:0] cfg_txid;
  logic        accept;
  dnsp_res_t   res;

  // a final byte needs a free slot in the output register
  assign byte_stall = result_valid && result_stall && byte_data.end_of_packet;
  assign accept     = byte_valid && !byte_stall;

  dnsp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_txid (cfg_txid)
  );

  dnsp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (byte_data),
    .cfg_txid (cfg_txid),
    .res      (res)
  );

  dnsp_result u_result (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

>>> tb/dns_response_address_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_response_address_parser_tb
// Self-checking bench for the byte-serial DNS response address parser.
// DNS packets are built one byte at a time and sent over the byte channel.
// A parse model inside the bench predicts the status and address for each
// final byte. Each result transfer is checked against the oldest prediction.
// Directed packets cover the header checks, found addresses, name forms,
// record skipping, truncation and the id register. Random traffic then runs
// under several id settings, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dns_response_address_parser_tb;
  import dnsp_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 4;
  localparam logic [2:0] ADDR_TXID    = {REG_TXID, 2'b00};
  localparam logic [2:0] ADDR_UNUSED  = {~REG_TXID, 2'b00};
  localparam logic [15:0] TYPE_CNAME  = 16'd5;
  localparam logic [15:0] TYPE_AAAA   = 16'd28;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  dnsp_in_t    byte_data = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  dnsp_out_t   result_data;

  dns_response_address_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // parse model state
  logic [15:0] txid_reg = '0;
  logic [3:0]  hdr_pos;
  phase_t      phase;
  logic [15:0] qd_left;
  logic [15:0] an_left;
  logic [7:0]  lbl_left;
  logic [3:0]  fld_pos;
  logic [15:0] rr_type;
  logic [15:0] rd_left;
  logic [31:0] addr_acc;
  logic        addr_found;

  dnsp_out_t   expected_replies[$];
  dnsp_out_t   want_reply;
  logic [7:0]  pkt[$];

  int cycle_count = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int results_seen = 0;
  int found_seen = 0;
  int txid_writes = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int stall_hold = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_parse_state();
    hdr_pos    = '0;
    phase      = PH_HEADER;
    qd_left    = '0;
    an_left    = '0;
    lbl_left   = '0;
    fld_pos    = '0;
    rr_type    = '0;
    rd_left    = '0;
    addr_acc   = '0;
    addr_found = 1'b0;
  endtask

  task automatic enter_answer_name();
    phase    = PH_ANAME;
    lbl_left = '0;
    fld_pos  = '0;
  endtask

  task automatic advance_answer();
    an_left = an_left - 16'd1;
    if (an_left == 0) phase = PH_DONE;
    else enter_answer_name();
  endtask

  // true when this byte closes the current name
  function automatic logic name_done(input logic [7:0] b);
    if (lbl_left != 0) begin
      lbl_left = lbl_left - 8'd1;
      return (lbl_left == 0) && (fld_pos == 4'd1);
    end
    if ((b & PTR_MASK) == PTR_MASK) begin
      // compression pointer: one more byte, then the name ends
      lbl_left = 8'd1;
      fld_pos  = 4'd1;
      return 1'b0;
    end
    if (b == 8'h00) return 1'b1;
    lbl_left = b;
    fld_pos  = 4'd0;
    return 1'b0;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    case (phase)
      PH_HEADER: begin
        if (hdr_pos < 4'd2) rr_type = {rr_type[7:0], b};
        else if (hdr_pos >= 4'd4 && hdr_pos < 4'd6) qd_left = {qd_left[7:0], b};
        else if (hdr_pos >= 4'd6 && hdr_pos < 4'd8) an_left = {an_left[7:0], b};
        if (hdr_pos == 4'd1 && rr_type != txid_reg) phase = PH_DONE;
        else if (hdr_pos == 4'd3 && (b & RCODE_MASK) != 0) phase = PH_DONE;
        else begin
          hdr_pos = hdr_pos + 4'd1;
          if (hdr_pos == HDR_LEN) begin
            rr_type = '0;
            if (an_left == 0) phase = PH_DONE;
            else begin
              lbl_left = '0;
              fld_pos  = '0;
              phase    = (qd_left == 0) ? PH_ANAME : PH_QNAME;
            end
          end
        end
      end
      PH_QNAME: begin
        if (name_done(b)) begin
          phase   = PH_QFIXED;
          fld_pos = '0;
        end
      end
      PH_QFIXED: begin
        fld_pos = fld_pos + 4'd1;
        if (fld_pos == QFIXED_LEN) begin
          qd_left  = qd_left - 16'd1;
          lbl_left = '0;
          fld_pos  = '0;
          phase    = (qd_left == 0) ? PH_ANAME : PH_QNAME;
        end
      end
      PH_ANAME: begin
        if (name_done(b)) begin
          phase   = PH_AFIXED;
          fld_pos = '0;
        end
      end
      PH_AFIXED: begin
        if (fld_pos < TYPE_END) rr_type = {rr_type[7:0], b};
        else if (fld_pos >= RDLEN_POS) rd_left = {rd_left[7:0], b};
        fld_pos = fld_pos + 4'd1;
        if (fld_pos == AFIXED_LEN) begin
          fld_pos = '0;
          if (rr_type == TYPE_A && rd_left == RDLEN_A) begin
            phase    = PH_ADDR;
            addr_acc = '0;
          end else if (rd_left != 0) begin
            phase = PH_RDATA;
          end else begin
            advance_answer();
          end
          rr_type = '0;
        end
      end
      PH_RDATA: begin
        rd_left = rd_left - 16'd1;
        if (rd_left == 0) advance_answer();
      end
      PH_ADDR: begin
        addr_acc = {addr_acc[23:0], b};
        fld_pos  = fld_pos + 4'd1;
        if (fld_pos == ADDR_LEN) begin
          addr_found = 1'b1;
          phase      = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(input dnsp_in_t item);
    absorb_byte(item.packet_byte);
    bytes_sent++;
    if (item.end_of_packet) begin
      if (addr_found) expected_replies.push_back('{status: 1'b0, ipv4_address: addr_acc});
      else expected_replies.push_back('{status: 1'b1, ipv4_address: 32'h0});
      packets_sent++;
      clear_parse_state();
    end
  endtask

  // byte sender: bursts of random length with random gaps between them
  task automatic send_byte(input dnsp_in_t item);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_data  <= item;
    do begin
      @(negedge clk);
      taken = !byte_stall;
      @(posedge clk);
    end while (!taken);
    predict_byte(item);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) begin
      send_byte('{packet_byte: pkt[i], end_of_packet: (i == pkt.size() - 1)});
    end
    pkt.delete();
  endtask

  // receiver stall pattern: random runs of stall cycles
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      result_stall <= 1'b1;
      stall_hold   <= $urandom_range(0, 4);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // inputs only move at the rising edge, so the falling edge sees settled values
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (result_data.status == 1'b0) found_seen++;
      if (expected_replies.size() == 0) begin
        report_mismatch("result transfer with nothing pending", result_data.ipv4_address, '0);
      end else begin
        want_reply = expected_replies.pop_front();
        if (result_data.status !== want_reply.status)
          report_mismatch("status", 32'(result_data.status), 32'(want_reply.status));
        if (result_data.ipv4_address !== want_reply.ipv4_address)
          report_mismatch("ipv4_address", result_data.ipv4_address, want_reply.ipv4_address);
      end
    end
  end

  task automatic wait_idle();
    byte_valid <= 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[2] == REG_TXID) txid_reg = data[15:0];
    // leave the bus idle before the next access
    @(posedge clk);
  endtask

  task automatic check_txid_readback();
    logic        done;
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TXID;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      got  = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[15:0] !== txid_reg) report_mismatch("txid readback", 32'(got[15:0]), 32'(txid_reg));
  endtask

  task automatic set_txid(input logic [15:0] id);
    wait_idle();
    // upper data bits are random, the register keeps only 16
    apb_write(ADDR_TXID, {16'($urandom), id});
    check_txid_readback();
    txid_writes++;
  endtask

  task automatic put8(input logic [7:0] v);
    pkt.push_back(v);
  endtask

  task automatic put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [3:0] rcode,
                            input logic [15:0] qd, input logic [15:0] an);
    put16(id);
    put8(8'($urandom));
    put8({4'($urandom), rcode});
    put16(qd);
    put16(an);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  task automatic put_name(input int labels, input bit to_pointer);
    int len;
    repeat (labels) begin
      len = $urandom_range(1, 6);
      put8(8'(len));
      repeat (len) put8(8'($urandom));
    end
    if (to_pointer) begin
      put8(PTR_MASK | 8'($urandom_range(0, 63)));
      put8(8'($urandom));
    end else begin
      put8(8'h00);
    end
  endtask

  task automatic put_question(input int labels, input bit to_pointer);
    put_name(labels, to_pointer);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  task automatic put_rr_fixed(input logic [15:0] rtype, input logic [15:0] rdlen,
                              input logic [31:0] addr);
    put16(rtype);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(rdlen);
    if (rtype == TYPE_A && rdlen == RDLEN_A) begin
      put16(addr[31:16]);
      put16(addr[15:0]);
    end else begin
      repeat (rdlen) put8(8'($urandom));
    end
  endtask

  task automatic put_rr(input logic [15:0] rtype, input logic [15:0] rdlen,
                        input logic [31:0] addr, input int labels, input bit to_pointer);
    put_name(labels, to_pointer);
    put_rr_fixed(rtype, rdlen, addr);
  endtask

  task automatic make_random_packet();
    int          pick;
    int          n_q;
    int          n_a;
    int          cut;
    logic [15:0] rtype;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // noise
      repeat ($urandom_range(1, 16)) put8(8'($urandom));
      return;
    end
    n_q = $urandom_range(0, 2);
    n_a = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
    put_header(($urandom_range(0, 9) == 0) ? 16'($urandom) : txid_reg,
               ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0,
               16'(n_q), 16'(n_a));
    repeat (n_q) put_question($urandom_range(0, 3), 1'($urandom_range(0, 1)));
    repeat (n_a) begin
      if ($urandom_range(0, 1) == 1) begin
        put_rr(TYPE_A,
               ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 8)) : RDLEN_A,
               $urandom, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 2))
          0: rtype = TYPE_CNAME;
          1: rtype = TYPE_AAAA;
          default: rtype = 16'($urandom);
        endcase
        put_rr(rtype, 16'($urandom_range(0, 6)), $urandom, $urandom_range(0, 2),
               1'($urandom_range(0, 1)));
      end
    end
    repeat ($urandom_range(0, 2)) put8(8'($urandom));
    if (pick < 27) begin
      // broken: cut short anywhere
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  task automatic test_header_checks();
    // lone final byte
    put8(8'h00);
    send_packet();
    // id mismatch in the top bit and the bottom bit
    put_header(txid_reg ^ 16'h8001, 4'h0, 16'd0, 16'd1);
    put_rr(TYPE_A, RDLEN_A, 32'h0A000001, 1, 1'b0);
    send_packet();
    put_header(txid_reg, 4'hF, 16'd0, 16'd1);
    put_rr(TYPE_A, RDLEN_A, 32'h0A000002, 1, 1'b0);
    send_packet();
    put_header(txid_reg, 4'h1, 16'd0, 16'd1);
    put_rr(TYPE_A, RDLEN_A, 32'h0A000003, 1, 1'b0);
    send_packet();
    // zero answers
    put_header(txid_reg, 4'h0, 16'd0, 16'd0);
    put_rr(TYPE_A, RDLEN_A, 32'h0A000004, 1, 1'b0);
    send_packet();
  endtask

  task automatic test_address_found();
    put_header(txid_reg, 4'h0, 16'd0, 16'd1);
    put_rr(TYPE_A, RDLEN_A, 32'hFFFFFFFF, 0, 1'b0);
    send_packet();
    // max answer count, bytes after the address are ignored
    put_header(txid_reg, 4'h0, 16'd1, 16'hFFFF);
    put_question(1, 1'b0);
    put_rr(TYPE_A, RDLEN_A, 32'h00000000, 2, 1'b1);
    repeat (3) put8(8'($urandom));
    send_packet();
  endtask

  task automatic test_name_forms();
    put_header(txid_reg, 4'h0, 16'd3, 16'd1);
    // label length above 0x3F still counts as a plain label
    put8(8'h45);
    repeat (8'h45) put8(8'($urandom));
    put8(8'h00);
    put16(16'($urandom));
    put16(16'($urandom));
    put_question(0, 1'b1);
    put8(PTR_MASK);
    put8(8'h00);
    put16(16'($urandom));
    put16(16'($urandom));
    // answer name: one label then an all-ones pointer
    put8(8'd3);
    repeat (3) put8(8'($urandom));
    put8(8'hFF);
    put8(8'hFF);
    put_rr_fixed(TYPE_A, RDLEN_A, $urandom);
    send_packet();
  endtask

  task automatic test_record_skipping();
    put_header(txid_reg, 4'h0, 16'd0, 16'd5);
    put_rr(TYPE_CNAME, 16'd3, 32'h0, 1, 1'b1);
    put_rr(TYPE_A, 16'd6, 32'h0, 0, 1'b0);
    put_rr(TYPE_AAAA, 16'd0, 32'h0, 0, 1'b1);
    put_rr(16'h0101, RDLEN_A, 32'h0, 1, 1'b0);
    put_rr(TYPE_A, RDLEN_A, 32'hC0A80101, 1, 1'b0);
    send_packet();
    // answers run out before any address record
    put_header(txid_reg, 4'h0, 16'd0, 16'd2);
    put_rr(TYPE_CNAME, 16'd2, 32'h0, 0, 1'b1);
    put_rr(TYPE_AAAA, RDLEN_A, 32'h0, 1, 1'b0);
    put_rr(TYPE_A, RDLEN_A, 32'h01020304, 0, 1'b0);
    send_packet();
  endtask

  task automatic test_truncation();
    int cut;
    // cut in the header, the name, the fixed fields and the address
    for (int k = 0; k < 4; k++) begin
      put_header(txid_reg, 4'h0, 16'd0, 16'd1);
      put_rr(TYPE_A, RDLEN_A, $urandom, 1, 1'b0);
      case (k)
        0: cut = 5;
        1: cut = 14;
        2: cut = pkt.size() - 8;
        default: cut = pkt.size() - 1;
      endcase
      while (pkt.size() > cut) void'(pkt.pop_back());
      send_packet();
    end
    put_header(txid_reg, 4'h0, 16'hFFFF, 16'd1);
    put_question(1, 1'b0);
    send_packet();
  endtask

  task automatic test_register();
    set_txid(16'hFFFF);
    put_header(txid_reg, 4'h0, 16'd0, 16'd1);
    put_rr(TYPE_A, RDLEN_A, $urandom, 1, 1'b1);
    send_packet();
    // the unused word must not disturb the id
    wait_idle();
    apb_write(ADDR_UNUSED, $urandom);
    check_txid_readback();
    put_header(txid_reg, 4'h0, 16'd0, 16'd1);
    put_rr(TYPE_A, RDLEN_A, $urandom, 0, 1'b0);
    send_packet();
    set_txid(16'($urandom));
    put_header(txid_reg, 4'h0, 16'd1, 16'd1);
    put_question(2, 1'b1);
    put_rr(TYPE_A, RDLEN_A, $urandom, 2, 1'b0);
    send_packet();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_txid(16'h0000);
          gap_max = 0;
          stall_pct = 0;
        end
        1: begin
          set_txid(16'hFFFF);
          gap_max = 4;
          stall_pct = 30;
        end
        2: begin
          set_txid(16'($urandom));
          gap_max = 0;
          stall_pct = 60;
        end
        3: begin
          set_txid(16'($urandom));
          gap_max = 6;
          stall_pct = 0;
        end
        4: begin
          set_txid(16'h8001);
          gap_max = 3;
          stall_pct = 20;
        end
        default: begin
          set_txid(16'($urandom));
          gap_max = 8;
          stall_pct = 50;
        end
      endcase
      make_random_packet();
      send_packet();
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             expected_replies.size());
    $display("[dns_response_address_parser] ERROR");
    $finish;
  end

  initial begin
    clear_parse_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_header_checks();
    gap_max = 3;
    stall_pct = 25;
    test_address_found();
    test_name_forms();
    test_record_skipping();
    test_truncation();
    test_register();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("sent %0d bytes in %0d packets under %0d id settings", bytes_sent,
             packets_sent, txid_writes);
    $display("checked %0d results, %0d with an address, %0d mismatches", results_seen,
             found_seen, mismatch_count);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("[dns_response_address_parser] OK");
    end else begin
      $display("[dns_response_address_parser] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dnsp_pkg.sv
sv/dnsp_cfg.sv
sv/dnsp_parser.sv
sv/dnsp_result.sv
sv/dns_response_address_parser.sv
tb/dns_response_address_parser_tb.sv
